@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion helper macros
// shared wrappers for clocked, reset-qualified property checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/idll_pkg.sv @@
// ----------------------------------------------------------------------------
// idll_pkg
// shared constants, status codes and controller command type
// ----------------------------------------------------------------------------
package idll_pkg;

  // default sizing
  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_VALUE_WIDTH = 64;

  // fixed port widths
  localparam int IDX_W  = 8;
  localparam int DATA_W = 64;

  typedef logic [IDX_W-1:0]  idx_port_t;
  typedef logic [DATA_W-1:0] data_port_t;

  // request opcodes
  localparam logic [1:0] OP_INS_AFTER  = 2'd0;
  localparam logic [1:0] OP_INS_BEFORE = 2'd1;
  localparam logic [1:0] OP_POP        = 2'd2;
  localparam logic [1:0] OP_UNDEF      = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic take;     // input word accepted this cycle
    logic rd_pos;   // read links and value at position
    logic rd_free;  // capture position links, read link at free head
    logic exec;     // decide operation, capture next free head
    logic wr1;      // first link write, scalar update
    logic wr2;      // second link write
    logic done;     // hand result to output register
  } cmd_t;

endpackage

@@ rtl/idll_ctrl.sv @@
// ----------------------------------------------------------------------------
// idll_ctrl
// sequencer stepping one operation through read, decide and write phases
// ----------------------------------------------------------------------------
module idll_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_full_i,
  output idll_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_POS,
    S_RD_FREE,
    S_EXEC,
    S_WR1,
    S_WR2,
    S_DONE
  } state_e;

  state_e         state_q;
  logic           ready_q;
  idll_pkg::cmd_t step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      step_q  <= '0;
    end else begin
      step_q <= '0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q       <= S_RD_POS;
            ready_q       <= 1'b0;
            step_q.rd_pos <= 1'b1;
          end
        end
        S_RD_POS: begin
          state_q        <= S_RD_FREE;
          step_q.rd_free <= 1'b1;
        end
        S_RD_FREE: begin
          state_q     <= S_EXEC;
          step_q.exec <= 1'b1;
        end
        S_EXEC: begin
          state_q    <= S_WR1;
          step_q.wr1 <= 1'b1;
        end
        S_WR1: begin
          state_q    <= S_WR2;
          step_q.wr2 <= 1'b1;
        end
        S_WR2: begin
          state_q     <= S_DONE;
          step_q.done <= 1'b1;
        end
        S_DONE: begin
          if (!out_full_i) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end else begin
            step_q.done <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o      = step_q;
    cmd_o.take = in_valid_i & ready_q;
  end

endmodule

@@ rtl/idll_dp.sv @@
// ----------------------------------------------------------------------------
// idll_dp
// link tables, value store, list pointers and result register
// ----------------------------------------------------------------------------
module idll_dp #(
  parameter int ENTRIES     = idll_pkg::DEF_ENTRIES,
  parameter int VALUE_WIDTH = idll_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  idll_pkg::cmd_t         cmd_i,
  output logic                   out_full_o,
  input  logic [1:0]             opcode_i,
  input  idll_pkg::idx_port_t    position_i,
  input  idll_pkg::data_port_t   value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output idll_pkg::data_port_t   popped_value_o,
  output idll_pkg::idx_port_t    head_index_o,
  output idll_pkg::idx_port_t    tail_index_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [idll_pkg::IDX_W:0] ENT_LIM = (idll_pkg::IDX_W + 1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    K_NONE,
    K_INS_EMPTY,
    K_INS_AFTER,
    K_INS_BEFORE,
    K_POP
  } kind_e;

  typedef logic [IW-1:0] ix_t;

  // storage
  ix_t                    next_mem [ENTRIES];
  ix_t                    prev_mem [ENTRIES];
  logic [VALUE_WIDTH-1:0] val_mem  [ENTRIES];
  logic [ENTRIES-1:0]     next_vld_q, prev_vld_q, used_q;

  // list pointers
  ix_t first_q, last_q, fhead_q;

  // latched request
  logic [1:0]             op_q;
  idll_pkg::idx_port_t    pos_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // read path
  ix_t                    nraddr, naddr_q, paddr_q, nrd_q, prd_q, next_eff, prev_eff;
  logic [VALUE_WIDTH-1:0] vrd_q;

  // operation context
  ix_t                    nx_q, pv_q, nfh_q, n_q;
  logic [VALUE_WIDTH-1:0] popv_q;
  kind_e                  kind_q, kind_d;
  idll_pkg::status_e      st_q, st_d;

  // write ports
  logic n_we, p_we;
  ix_t  n_wa, n_wd, p_wa, p_wd;

  // result register
  logic                   rvalid_q;
  idll_pkg::status_e      rstat_q;
  logic [VALUE_WIDTH-1:0] rpop_q;
  ix_t                    rhead_q, rtail_q;
  logic                   load_out;

  ix_t pos_ix;
  assign pos_ix = pos_q[IW-1:0];

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= value_i[VALUE_WIDTH-1:0];
    end
  end

  // registered reads; next table reads position then free head
  assign nraddr = cmd_i.rd_pos ? pos_ix : fhead_q;

  always_ff @(posedge clk_i) begin
    nrd_q   <= next_mem[nraddr];
    naddr_q <= nraddr;
    prd_q   <= prev_mem[pos_ix];
    paddr_q <= pos_ix;
    vrd_q   <= val_mem[pos_ix];
  end

  // entries never written read as their reset links
  always_comb begin
    if (next_vld_q[naddr_q]) begin
      next_eff = nrd_q;
    end else if (naddr_q == LAST_IDX) begin
      next_eff = '0;
    end else begin
      next_eff = naddr_q + ix_t'(1);
    end
    prev_eff = prev_vld_q[paddr_q] ? prd_q : '0;
  end

  // operation decode
  always_comb begin
    kind_d = K_NONE;
    st_d   = idll_pkg::ST_REFUSED;
    if ({1'b0, pos_q} >= ENT_LIM) begin
      st_d = idll_pkg::ST_RANGE;
    end else if (op_q == idll_pkg::OP_INS_AFTER || op_q == idll_pkg::OP_INS_BEFORE) begin
      if (fhead_q == '0) begin
        st_d = idll_pkg::ST_REFUSED;
      end else if (first_q == '0) begin
        st_d   = idll_pkg::ST_OK;
        kind_d = K_INS_EMPTY;
      end else if (pos_q == '0 || !used_q[pos_ix]) begin
        st_d = idll_pkg::ST_REFUSED;
      end else begin
        st_d   = idll_pkg::ST_OK;
        kind_d = (op_q == idll_pkg::OP_INS_AFTER) ? K_INS_AFTER : K_INS_BEFORE;
      end
    end else if (op_q == idll_pkg::OP_POP) begin
      if (pos_q == '0) begin
        st_d = idll_pkg::ST_ZERO;
      end else if (!used_q[pos_ix]) begin
        st_d = idll_pkg::ST_REFUSED;
      end else begin
        st_d   = idll_pkg::ST_OK;
        kind_d = K_POP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_free) begin
      nx_q   <= next_eff;
      pv_q   <= prev_eff;
      popv_q <= vrd_q;
    end
    if (cmd_i.exec) begin
      nfh_q <= next_eff;
      n_q   <= fhead_q;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= K_NONE;
    end else if (cmd_i.exec) begin
      kind_q <= kind_d;
    end
  end

  // link writes, one per table per phase
  always_comb begin
    n_we = 1'b0;
    n_wa = '0;
    n_wd = '0;
    p_we = 1'b0;
    p_wa = '0;
    p_wd = '0;
    if (cmd_i.wr1) begin
      case (kind_q)
        K_INS_EMPTY: begin
          n_we = 1'b1; n_wa = n_q; n_wd = '0;
          p_we = 1'b1; p_wa = n_q; p_wd = '0;
        end
        K_INS_AFTER: begin
          n_we = 1'b1; n_wa = n_q; n_wd = nx_q;
          p_we = 1'b1; p_wa = n_q; p_wd = pos_ix;
        end
        K_INS_BEFORE: begin
          n_we = 1'b1; n_wa = n_q; n_wd = pos_ix;
          p_we = 1'b1; p_wa = n_q; p_wd = pv_q;
        end
        K_POP: begin
          n_we = 1'b1; n_wa = pos_ix; n_wd = fhead_q;
          p_we = 1'b1; p_wa = pos_ix; p_wd = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.wr2) begin
      case (kind_q)
        K_INS_AFTER: begin
          n_we = 1'b1;         n_wa = pos_ix; n_wd = n_q;
          p_we = (nx_q != '0); p_wa = nx_q;   p_wd = n_q;
        end
        K_INS_BEFORE: begin
          n_we = (pv_q != '0); n_wa = pv_q;   n_wd = n_q;
          p_we = 1'b1;         p_wa = pos_ix; p_wd = n_q;
        end
        K_POP: begin
          n_we = (pv_q != '0); n_wa = pv_q; n_wd = nx_q;
          p_we = (nx_q != '0); p_wa = nx_q; p_wd = pv_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    if (p_we) begin
      prev_mem[p_wa] <= p_wd;
    end
    if (cmd_i.wr1 && (kind_q == K_INS_EMPTY || kind_q == K_INS_AFTER ||
                      kind_q == K_INS_BEFORE)) begin
      val_mem[n_q] <= val_q;
    end
  end

  // valid bits, in-use marks and list pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q <= '0;
      prev_vld_q <= '0;
      used_q     <= '0;
      first_q    <= '0;
      last_q     <= '0;
      fhead_q    <= ix_t'(1);
    end else begin
      if (n_we) begin
        next_vld_q[n_wa] <= 1'b1;
      end
      if (p_we) begin
        prev_vld_q[p_wa] <= 1'b1;
      end
      if (cmd_i.wr1) begin
        case (kind_q)
          K_INS_EMPTY: begin
            first_q     <= n_q;
            last_q      <= n_q;
            fhead_q     <= nfh_q;
            used_q[n_q] <= 1'b1;
          end
          K_INS_AFTER: begin
            fhead_q     <= nfh_q;
            used_q[n_q] <= 1'b1;
            if (nx_q == '0) begin
              last_q <= n_q;
            end
          end
          K_INS_BEFORE: begin
            fhead_q     <= nfh_q;
            used_q[n_q] <= 1'b1;
            if (pv_q == '0) begin
              first_q <= n_q;
            end
          end
          K_POP: begin
            fhead_q        <= pos_ix;
            used_q[pos_ix] <= 1'b0;
            if (pv_q == '0) begin
              first_q <= nx_q;
            end
            if (nx_q == '0) begin
              last_q <= pv_q;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  assign load_out = cmd_i.done & ~rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (load_out) begin
      rvalid_q <= 1'b1;
    end else if (out_ready_i) begin
      rvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rstat_q <= st_q;
      rpop_q  <= (kind_q == K_POP) ? popv_q : '0;
      rhead_q <= first_q;
      rtail_q <= last_q;
    end
  end

  assign out_full_o     = rvalid_q;
  assign out_valid_o    = rvalid_q;
  assign status_o       = rstat_q;
  assign popped_value_o = idll_pkg::data_port_t'(rpop_q);
  assign head_index_o   = idll_pkg::idx_port_t'(rhead_q);
  assign tail_index_o   = idll_pkg::idx_port_t'(rtail_q);

endmodule

@@ rtl/indexed_doubly_linked_list.sv @@
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// table-based doubly linked list with free chain: insert after, insert
// before and pop at a table position, one result word per request word
// steps: reads, decide, two link writes, load once the output is free
// one word in flight, set by the single write port per link table (two
//   link writes per table per operation) and registered reads
// reset: async active low; empty list, free chain 1..N-1, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_doubly_linked_list #(
  parameter int ENTRIES     = idll_pkg::DEF_ENTRIES,
  parameter int VALUE_WIDTH = idll_pkg::DEF_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  idll_pkg::idx_port_t   position_i,
  input  idll_pkg::data_port_t  value_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output idll_pkg::data_port_t  popped_value_o,
  output idll_pkg::idx_port_t   head_index_o,
  output idll_pkg::idx_port_t   tail_index_o
);

  // commands from the sequencer, output-register occupancy back
  idll_pkg::cmd_t cmd;
  logic           out_full;

  // sequencer: fixed read / decide / write walk for every word
  idll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_full_i (out_full),
    .cmd_o      (cmd)
  );

  // datapath: link tables, value store, head / tail / free head, result reg
  idll_dp #(
    .ENTRIES     (ENTRIES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .out_full_o     (out_full),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .head_index_o   (head_index_o),
    .tail_index_o   (tail_index_o)
  );

  // only one word in flight inside the sequencer
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
               "request accepted while a word is in flight")

  // a failed operation never reports a popped value
  `ASSERT_SAME(a_pop_zero, clk_i, rst_ni,
               out_valid_o && status_o != idll_pkg::ST_OK, popped_value_o == '0,
               "popped value set on a failed operation")

  // head and tail are empty together
  `ASSERT_SAME(a_ends_agree, clk_i, rst_ni, out_valid_o,
               (head_index_o == '0) == (tail_index_o == '0),
               "head and tail disagree on list emptiness")

  // list ends stay inside the table
  `ASSERT_SAME(a_ends_range, clk_i, rst_ni, out_valid_o,
               head_index_o < ENTRIES && tail_index_o < ENTRIES,
               "list end index outside the table")

endmodule
